// File: design/bayer_demosaic_mhc_5x5_assert.svh
// Assertion macros for the Bayer demosaic block.
// Included by the top level; depends on nothing else.
`ifndef BAYER_DEMOSAIC_MHC_5X5_ASSERT_SVH
`define BAYER_DEMOSAIC_MHC_5X5_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bdm_pkg.sv
// Shared types, constants and tap-mapping functions of the Bayer demosaic block.
// No dependencies.
package bdm_pkg;

    localparam int PIX_W          = 8;
    localparam int WIN_N          = 5;
    localparam int WIN_TAPS       = WIN_N * WIN_N;
    localparam int DIM_W          = 11;
    localparam int MIN_DIM        = 5;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int LANES          = 4;
    localparam int LANE_W         = $clog2(LANES);
    localparam int JOB_DEPTH      = 4;
    localparam int JOB_PTR_W      = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W      = $clog2(JOB_DEPTH + 1);
    localparam int KSUM_W         = 15;
    localparam int TAP_IDX_W      = $clog2(WIN_TAPS);

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd390;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd300;

    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    // Row position of the output pixel relative to the frame borders
    typedef enum logic [2:0]
    {
        RCLS_MID  = 3'd0,
        RCLS_TOP0 = 3'd1,
        RCLS_TOP1 = 3'd2,
        RCLS_BOT1 = 3'd3,
        RCLS_BOT0 = 3'd4
    } rcls_t;

    // Column position of the output pixel relative to the frame borders
    typedef enum logic [2:0]
    {
        CCLS_MID    = 3'd0,
        CCLS_LEFT0  = 3'd1,
        CCLS_LEFT1  = 3'd2,
        CCLS_RIGHT1 = 3'd3,
        CCLS_RIGHT0 = 3'd4
    } ccls_t;

    typedef logic [WIN_TAPS-1:0][PIX_W-1:0] win_t;

    typedef struct packed
    {
        rcls_t rcls;
        logic  y_odd;
        ccls_t ccls;
        logic  x_odd;
        logic  row_end;
        logic  frame_last;
        logic  w_odd;
    } job_info_t;

    typedef struct packed
    {
        win_t      win;
        job_info_t info;
    } job_t;

    typedef struct packed
    {
        logic [JOB_CNT_W-1:0] count;
        logic                 full;
        logic                 empty;
    } q_stat_t;

    // Window row holding offset dy, with mirror reflection at the frame edges
    function automatic logic [2:0] row_tap(rcls_t cls, int dy);
        int pos;
        pos = 2 + dy;
        case (cls)
            RCLS_TOP0: if (dy < 0) pos = 2 - dy;
            RCLS_TOP1: if (dy == -2) pos = 2;
            RCLS_BOT1: if (dy == 2) pos = 2;
            RCLS_BOT0: if (dy > 0) pos = 2 - dy;
            default:   pos = 2 + dy;
        endcase
        return 3'(pos);
    endfunction

    // Window column holding offset dx; right-edge pixels sit nearer the newest column
    function automatic logic [2:0] col_tap(ccls_t cls, int dx);
        int pos;
        pos = 2 + dx;
        case (cls)
            CCLS_LEFT0:  if (dx < 0) pos = 2 - dx;
            CCLS_LEFT1:  if (dx == -2) pos = 2;
            CCLS_RIGHT1: pos = (dx == 2) ? 3 : 3 + dx;
            CCLS_RIGHT0: pos = (dx > 0) ? 4 - dx : 4 + dx;
            default:     pos = 2 + dx;
        endcase
        return 3'(pos);
    endfunction

    function automatic logic [TAP_IDX_W-1:0] tap_index(rcls_t rc, ccls_t cc, int dy, int dx);
        int idx;
        idx = int'(row_tap(rc, dy)) * WIN_N + int'(col_tap(cc, dx));
        return TAP_IDX_W'(idx);
    endfunction

    // Divide by 16 with floor and clip to the pixel range
    function automatic logic [PIX_W-1:0] finish(logic signed [KSUM_W-1:0] s);
        logic [KSUM_W-6:0] q;
        q = s[KSUM_W-2:4];
        if (s < 0)
            return '0;
        else if (q > (KSUM_W-5)'(255))
            return 8'hff;
        else
            return q[PIX_W-1:0];
    endfunction

endpackage

// File: design/bdm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/bdm_front.sv
// Front end: input acceptance, raster position, line store and 5x5 window.
// Depends on bdm_pkg and bdm_ram; pushes one job per pixel that yields output.
module bdm_front #(
    parameter int MAX_WIDTH  = bdm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bdm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            action,
    input  logic [bdm_pkg::PIX_W-1:0]       raw_pixel,
    input  logic [bdm_pkg::DIM_W-1:0]       frame_width,
    input  logic [bdm_pkg::DIM_W-1:0]       frame_height,
    input  logic                            restart,
    input  bdm_pkg::q_stat_t                q_stat,
    output logic                            q_push,
    output bdm_pkg::job_t                   q_data
);
    import bdm_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int WX_A  = $clog2(MAX_WIDTH + 1);
    localparam int HX_A  = $clog2(MAX_HEIGHT + 3);
    localparam int WX    = (WX_A > DIM_W) ? WX_A : DIM_W;
    localparam int HX    = (HX_A > DIM_W) ? HX_A : DIM_W;
    localparam int WORD_W = LANES * PIX_W;

    logic [WX-1:0] w_raw, w_eff;
    logic [HX-1:0] h_raw, h_eff;

    logic [CW-1:0] col_reg, col_next, c_use;
    logic [RW-1:0] row_reg, row_next, r_use;
    logic [WX-1:0] c_ext, c_inc;
    logic [HX-1:0] r_ext, r_inc;
    logic          wrap, in_frame, take;
    logic [PIX_W-1:0] pix;
    job_info_t     info;
    logic          has_job;

    logic                 f1_valid_reg;
    logic                 f1_job_reg;
    logic [PIX_W-1:0]     f1_pix_reg;
    logic [LANE_W-1:0]    f1_lane_reg;
    logic [CW-1:0]        f1_col_reg;
    job_info_t            f1_info_reg;

    logic [WORD_W-1:0]    rd_word, wr_word;
    win_t                 win_reg, win_next;
    logic [LANE_W-1:0]    lane_k;

    always_comb
    begin
        w_raw = WX'(frame_width);
        h_raw = HX'(frame_height);
        if (w_raw < WX'(MIN_DIM))
            w_eff = WX'(MIN_DIM);
        else if (w_raw > WX'(MAX_WIDTH))
            w_eff = WX'(MAX_WIDTH);
        else
            w_eff = w_raw;
        if (h_raw < HX'(MIN_DIM))
            h_eff = HX'(MIN_DIM);
        else if (h_raw > HX'(MAX_HEIGHT))
            h_eff = HX'(MAX_HEIGHT);
        else
            h_eff = h_raw;
    end

    // Room for the job still in the second stage plus the one accepted now
    assign s_tready = ({1'b0, q_stat.count} + (JOB_CNT_W+1)'(f1_valid_reg && f1_job_reg))
                      < (JOB_CNT_W+1)'(JOB_DEPTH);

    always_comb
    begin
        wrap = (HX'(row_reg) >= h_eff + HX'(2)) || (WX'(col_reg) >= w_eff);
        r_use = wrap ? '0 : row_reg;
        c_use = wrap ? '0 : col_reg;
        r_ext = HX'(r_use);
        c_ext = WX'(c_use);
        in_frame = r_ext < h_eff;
        // drop an early flush tick: no result, no state change
        take = s_tvalid && s_tready && !(in_frame && action);
        pix = in_frame ? raw_pixel : '0;

        c_inc = c_ext + WX'(1);
        r_inc = r_ext + HX'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (take)
        begin
            if (c_inc >= w_eff)
            begin
                col_next = '0;
                row_next = (r_inc >= h_eff + HX'(2)) ? '0 : RW'(r_inc);
            end
            else
            begin
                col_next = CW'(c_inc);
                row_next = r_use;
            end
        end

        has_job = (r_ext >= HX'(2)) && (c_ext >= WX'(2));
        if (r_ext == HX'(2))
            info.rcls = RCLS_TOP0;
        else if (r_ext == HX'(3))
            info.rcls = RCLS_TOP1;
        else if (r_ext == h_eff)
            info.rcls = RCLS_BOT1;
        else if (r_ext == h_eff + HX'(1))
            info.rcls = RCLS_BOT0;
        else
            info.rcls = RCLS_MID;
        if (c_ext == WX'(2))
            info.ccls = CCLS_LEFT0;
        else if (c_ext == WX'(3))
            info.ccls = CCLS_LEFT1;
        else
            info.ccls = CCLS_MID;
        info.y_odd      = r_use[0];
        info.x_odd      = c_use[0];
        info.row_end    = (c_inc == w_eff);
        info.frame_last = (c_inc == w_eff) && (r_ext == h_eff + HX'(1));
        info.w_odd      = w_eff[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            f1_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            f1_valid_reg <= take;
            win_reg      <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f1_job_reg  <= has_job;
            f1_pix_reg  <= pix;
            f1_lane_reg <= r_use[LANE_W-1:0];
            f1_col_reg  <= c_use;
            f1_info_reg <= info;
        end
    end

    bdm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (f1_valid_reg),
        .wr_addr (f1_col_reg),
        .wr_data (wr_word),
        .rd_en   (take),
        .rd_addr (c_use),
        .rd_data (rd_word)
    );

    always_comb
    begin
        wr_word = rd_word;
        wr_word[f1_lane_reg*PIX_W +: PIX_W] = f1_pix_reg;

        win_next = win_reg;
        lane_k = '0;
        if (f1_valid_reg)
        begin
            for (int k = 0; k < WIN_N; k++)
            begin
                for (int j = 0; j < WIN_N - 1; j++)
                begin
                    win_next[k*WIN_N + j] = win_reg[k*WIN_N + j + 1];
                end
            end
            // oldest row first: line row (r + k) mod 4 holds frame row r - 4 + k
            for (int k = 0; k < LANES; k++)
            begin
                lane_k = f1_lane_reg + LANE_W'(k);
                win_next[k*WIN_N + WIN_N - 1] = rd_word[lane_k*PIX_W +: PIX_W];
            end
            win_next[WIN_TAPS-1] = f1_pix_reg;
        end
    end

    assign q_push    = f1_valid_reg && f1_job_reg;
    assign q_data.win  = win_next;
    assign q_data.info = f1_info_reg;

endmodule

// File: design/bdm_queue.sv
// Short job queue between the front end and the kernel pipeline.
// Depends on bdm_pkg.
module bdm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bdm_pkg::job_t    push_data,
    input  logic             pop,
    output bdm_pkg::job_t    head,
    output bdm_pkg::q_stat_t stat
);
    import bdm_pkg::*;

    job_t                 entry [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOB_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JOB_CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + JOB_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + JOB_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + JOB_CNT_W'(push) - JOB_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = entry[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = (count_reg == JOB_CNT_W'(JOB_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// File: design/bdm_back.sv
// Back end: expands jobs into output pixels and runs the 5x5 kernels.
// Depends on bdm_pkg. Gather, kernel sums and clip/select are three stages.
module bdm_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bdm_pkg::job_t                  head,
    input  bdm_pkg::q_stat_t               q_stat,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [3*bdm_pkg::PIX_W-1:0]    m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);
    import bdm_pkg::*;

    typedef logic signed [KSUM_W-1:0] ksum_t;

    logic        en, issue, last;
    logic [1:0]  k_reg, k_next;
    ccls_t       cc;
    logic        x_odd;

    logic             b1_valid_reg;
    logic [PIX_W-1:0] b1_ctr_reg, b1_u1_reg, b1_d1_reg, b1_l1_reg, b1_r1_reg;
    logic [PIX_W-1:0] b1_u2_reg, b1_d2_reg, b1_l2_reg, b1_r2_reg;
    logic [PIX_W-1:0] b1_dg0_reg, b1_dg1_reg, b1_dg2_reg, b1_dg3_reg;
    logic             b1_y_odd_reg, b1_x_odd_reg, b1_last_reg, b1_fend_reg;

    ksum_t c_s, u1_s, d1_s, l1_s, r1_s, u2_s, d2_s, l2_s, r2_s, dg_s;
    ksum_t kh_next, kv_next, kg_next, kx_next;

    logic             b2_valid_reg;
    ksum_t            b2_kh_reg, b2_kv_reg, b2_kg_reg, b2_kx_reg;
    logic [PIX_W-1:0] b2_ctr_reg;
    logic             b2_y_odd_reg, b2_x_odd_reg, b2_last_reg, b2_fend_reg;

    logic [PIX_W-1:0] red_next, green_next, blue_next;
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_red_reg, out_green_reg, out_blue_reg;
    logic             out_last_reg, out_fend_reg;

    // whole pipeline advances together whenever the output register can move
    assign en    = !out_valid_reg || m_tready;
    assign issue = en && !q_stat.empty;
    // a row-end job yields columns W-3, W-2 and W-1 from the same window
    assign last  = !head.info.row_end || (k_reg == 2'd2);
    assign pop   = issue && last;

    always_comb
    begin
        k_next = k_reg;
        if (issue)
            k_next = last ? 2'd0 : k_reg + 2'd1;
        case (k_reg)
            2'd1:
            begin
                cc    = CCLS_RIGHT1;
                x_odd = head.info.w_odd;
            end
            2'd2:
            begin
                cc    = CCLS_RIGHT0;
                x_odd = !head.info.w_odd;
            end
            default:
            begin
                cc    = head.info.ccls;
                x_odd = head.info.x_odd;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= 2'd0;
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg <= k_next;
            if (en)
            begin
                b1_valid_reg  <= issue;
                b2_valid_reg  <= b1_valid_reg;
                out_valid_reg <= b2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_ctr_reg   <= head.win[tap_index(head.info.rcls, cc,  0,  0)];
            b1_u1_reg    <= head.win[tap_index(head.info.rcls, cc, -1,  0)];
            b1_d1_reg    <= head.win[tap_index(head.info.rcls, cc,  1,  0)];
            b1_l1_reg    <= head.win[tap_index(head.info.rcls, cc,  0, -1)];
            b1_r1_reg    <= head.win[tap_index(head.info.rcls, cc,  0,  1)];
            b1_u2_reg    <= head.win[tap_index(head.info.rcls, cc, -2,  0)];
            b1_d2_reg    <= head.win[tap_index(head.info.rcls, cc,  2,  0)];
            b1_l2_reg    <= head.win[tap_index(head.info.rcls, cc,  0, -2)];
            b1_r2_reg    <= head.win[tap_index(head.info.rcls, cc,  0,  2)];
            b1_dg0_reg   <= head.win[tap_index(head.info.rcls, cc, -1, -1)];
            b1_dg1_reg   <= head.win[tap_index(head.info.rcls, cc, -1,  1)];
            b1_dg2_reg   <= head.win[tap_index(head.info.rcls, cc,  1, -1)];
            b1_dg3_reg   <= head.win[tap_index(head.info.rcls, cc,  1,  1)];
            b1_y_odd_reg <= head.info.y_odd;
            b1_x_odd_reg <= x_odd;
            b1_last_reg  <= last;
            b1_fend_reg  <= head.info.frame_last && last;

            b2_kh_reg    <= kh_next;
            b2_kv_reg    <= kv_next;
            b2_kg_reg    <= kg_next;
            b2_kx_reg    <= kx_next;
            b2_ctr_reg   <= b1_ctr_reg;
            b2_y_odd_reg <= b1_y_odd_reg;
            b2_x_odd_reg <= b1_x_odd_reg;
            b2_last_reg  <= b1_last_reg;
            b2_fend_reg  <= b1_fend_reg;

            out_red_reg   <= red_next;
            out_green_reg <= green_next;
            out_blue_reg  <= blue_next;
            out_last_reg  <= b2_last_reg;
            out_fend_reg  <= b2_fend_reg;
        end
    end

    always_comb
    begin
        c_s  = ksum_t'({7'd0, b1_ctr_reg});
        u1_s = ksum_t'({7'd0, b1_u1_reg});
        d1_s = ksum_t'({7'd0, b1_d1_reg});
        l1_s = ksum_t'({7'd0, b1_l1_reg});
        r1_s = ksum_t'({7'd0, b1_r1_reg});
        u2_s = ksum_t'({7'd0, b1_u2_reg});
        d2_s = ksum_t'({7'd0, b1_d2_reg});
        l2_s = ksum_t'({7'd0, b1_l2_reg});
        r2_s = ksum_t'({7'd0, b1_r2_reg});
        dg_s = ksum_t'({7'd0, b1_dg0_reg}) + ksum_t'({7'd0, b1_dg1_reg})
             + ksum_t'({7'd0, b1_dg2_reg}) + ksum_t'({7'd0, b1_dg3_reg});

        kh_next = KSUM_W'(10 * c_s + 8 * (l1_s + r1_s) - 2 * (l2_s + r2_s)
                          - 2 * dg_s + (u2_s + d2_s));
        kv_next = KSUM_W'(10 * c_s + 8 * (u1_s + d1_s) - 2 * (u2_s + d2_s)
                          - 2 * dg_s + (l2_s + r2_s));
        kg_next = KSUM_W'(8 * c_s + 4 * (u1_s + d1_s + l1_s + r1_s)
                          - 2 * (u2_s + d2_s + l2_s + r2_s));
        kx_next = KSUM_W'(12 * c_s + 4 * dg_s - 3 * (u2_s + d2_s + l2_s + r2_s));
    end

    always_comb
    begin
        case ({b2_y_odd_reg, b2_x_odd_reg})
            2'b00:
            begin
                red_next   = finish(b2_kh_reg);
                green_next = b2_ctr_reg;
                blue_next  = finish(b2_kv_reg);
            end
            2'b01:
            begin
                red_next   = b2_ctr_reg;
                green_next = finish(b2_kg_reg);
                blue_next  = finish(b2_kx_reg);
            end
            2'b10:
            begin
                red_next   = finish(b2_kx_reg);
                green_next = finish(b2_kg_reg);
                blue_next  = b2_ctr_reg;
            end
            default:
            begin
                red_next   = finish(b2_kv_reg);
                green_next = b2_ctr_reg;
                blue_next  = finish(b2_kh_reg);
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_blue_reg, out_green_reg, out_red_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_fend_reg;

endmodule

// File: design/bayer_demosaic_mhc_5x5.sv
// Bayer GRBG to RGB demosaic, 5x5 Malvar-He-Cutler kernels, mirrored borders.
// Throughput: one input per cycle while s_tready is high; one output per cycle while
// m_tready is high, the last pixel of a row yielding three outputs back to back
// from the same window through the job queue. Path: line-store read, queue, gather,
// kernel sum and clip/select register, whose output drives m_tvalid.
// Reset: asynchronous, clears position, pipeline and queue; line store left as is.
`include "bayer_demosaic_mhc_5x5_assert.svh"

module bayer_demosaic_mhc_5x5 #(
    parameter int MAX_WIDTH  = bdm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bdm_pkg::MAX_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] raw_pixel
    input  logic [0:0]  s_tuser,   // [0] action
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic        m_tlast,   // run_end
    output logic [0:0]  m_tuser,   // [0] frame_end
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bdm_pkg::*;

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    q_stat_t q_stat;
    logic    q_push, q_pop;
    job_t    q_data, q_head;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_FRAME_WIDTH:  width_next  = pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: height_next = pwdata[DIM_W-1:0];
                default:          width_next  = width_reg;
            endcase
        end
        case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = 32'(width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    bdm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .action       (s_tuser[0]),
        .raw_pixel    (s_tdata),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .restart      (cfg_wr),
        .q_stat       (q_stat),
        .q_push       (q_push),
        .q_data       (q_data)
    );

    bdm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    bdm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .q_stat   (q_stat),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser[0])
    );

    `BDM_ASSERT_NOW(a_no_overflow, clk, rst_n, q_push, !q_stat.full || q_pop, "job queue overflow")
    `BDM_ASSERT_NOW(a_no_underflow, clk, rst_n, q_pop, !q_stat.empty, "pop from empty job queue")
    `BDM_ASSERT_NOW(a_frame_end_last, clk, rst_n, m_tvalid && m_tuser[0], m_tlast, "frame end without run end")

endmodule

// File: tb/tb_bayer_demosaic_mhc_5x5.sv
// Self-checking testbench for the GRBG Malvar-He-Cutler demosaic block.
// Depends on bdm_pkg and bayer_demosaic_mhc_5x5; a scoreboard class predicts every RGB pixel.
module tb_bayer_demosaic_mhc_5x5;
    timeunit 1ns;
    timeprecision 1ps;
    import bdm_pkg::*;

    typedef struct
    {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       run_end;
        logic       frame_end;
    } rgb_pix_t;

    class rgb_scoreboard;
        byte unsigned line_mem[4][1024];
        byte unsigned win[25];
        int           row;
        int           col;
        int           width_reg;
        int           height_reg;
        rgb_pix_t     pending[$];
        int           errors;
        int           matched;

        function new();
            width_reg  = 390;
            height_reg = 300;
        endfunction

        function void write_reg(reg_idx_t idx, int value);
            if (idx == REG_FRAME_WIDTH)
                width_reg = value & 'h7ff;
            else
                height_reg = value & 'h7ff;
            row = 0;
            col = 0;
        endfunction

        function int clamp_dim(int v);
            return (v < 5) ? 5 : (v > 1024) ? 1024 : v;
        endfunction

        function int mirror(int p, int n);
            if (p < 0)
                return -p;
            if (p >= n)
                return 2 * n - 2 - p;
            return p;
        endfunction

        // Sample at (y+dy, x+dx) from the window whose newest tap is input (r, c)
        function int tap(int y, int x, int dy, int dx, int r, int c, int w, int h);
            int pr;
            int pc;
            pr = mirror(y + dy, h) - (r - 4);
            pc = mirror(x + dx, w) - (c - 4);
            if (pr < 0 || pr > 4 || pc < 0 || pc > 4)
                return 0;
            return win[pr * 5 + pc];
        endfunction

        function logic [7:0] clip16(int s);
            if (s < 0)
                return 8'd0;
            s = s / 16;
            return (s > 255) ? 8'd255 : s[7:0];
        endfunction

        function void predict_pixel(int y, int x, int r, int c, int w, int h, bit last);
            int ctr, u1, d1, l1, r1, u2, d2, l2, r2, dg, kh, kv, kg, kx;
            rgb_pix_t p;
            ctr = tap(y, x, 0, 0, r, c, w, h);
            u1  = tap(y, x, -1, 0, r, c, w, h);
            d1  = tap(y, x, 1, 0, r, c, w, h);
            l1  = tap(y, x, 0, -1, r, c, w, h);
            r1  = tap(y, x, 0, 1, r, c, w, h);
            u2  = tap(y, x, -2, 0, r, c, w, h);
            d2  = tap(y, x, 2, 0, r, c, w, h);
            l2  = tap(y, x, 0, -2, r, c, w, h);
            r2  = tap(y, x, 0, 2, r, c, w, h);
            dg  = tap(y, x, -1, -1, r, c, w, h) + tap(y, x, -1, 1, r, c, w, h)
                + tap(y, x, 1, -1, r, c, w, h) + tap(y, x, 1, 1, r, c, w, h);
            kh = 10 * ctr + 8 * (l1 + r1) - 2 * (l2 + r2) - 2 * dg + (u2 + d2);
            kv = 10 * ctr + 8 * (u1 + d1) - 2 * (u2 + d2) - 2 * dg + (l2 + r2);
            kg = 8 * ctr + 4 * (u1 + d1 + l1 + r1) - 2 * (u2 + d2 + l2 + r2);
            kx = 12 * ctr + 4 * dg - 3 * (u2 + d2 + l2 + r2);
            if (y % 2 == 0 && x % 2 == 0)
            begin
                p.red = clip16(kh); p.green = ctr[7:0]; p.blue = clip16(kv);
            end
            else if (y % 2 == 0)
            begin
                p.red = ctr[7:0]; p.green = clip16(kg); p.blue = clip16(kx);
            end
            else if (x % 2 == 0)
            begin
                p.red = clip16(kx); p.green = clip16(kg); p.blue = ctr[7:0];
            end
            else
            begin
                p.red = clip16(kv); p.green = ctr[7:0]; p.blue = clip16(kh);
            end
            p.run_end   = last;
            p.frame_end = (y == h - 1 && x == w - 1);
            pending.push_back(p);
        endfunction

        function void note_input(bit flush, byte unsigned pixel);
            int w;
            int h;
            int r;
            int c;
            byte unsigned v;
            w = clamp_dim(width_reg);
            h = clamp_dim(height_reg);
            r = row;
            c = col;
            v = 0;
            if (r >= h + 2 || c >= w)
            begin
                r = 0;
                c = 0;
            end
            // drop a flush that arrives while frame rows are still due
            if (r < h)
            begin
                if (flush)
                    return;
                v = pixel;
            end
            for (int k = 0; k < 5; k++)
                for (int j = 0; j < 4; j++)
                    win[k * 5 + j] = win[k * 5 + j + 1];
            for (int k = 0; k < 4; k++)
                win[k * 5 + 4] = line_mem[(r + k) % 4][c];
            win[24] = v;
            line_mem[r % 4][c] = v;
            if (r >= 2 && c >= 2)
            begin
                predict_pixel(r - 2, c - 2, r, c, w, h, c != w - 1);
                if (c == w - 1)
                begin
                    pending[$].run_end = 1'b0;
                    predict_pixel(r - 2, w - 2, r, c, w, h, 1'b0);
                    predict_pixel(r - 2, w - 1, r, c, w, h, 1'b1);
                end
            end
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
                if (r >= h + 2)
                    r = 0;
            end
            row = r;
            col = c;
        endfunction

        function void check_result(logic [23:0] data, logic last, logic fend);
            rgb_pix_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected pixel %h last %b frame_end %b", $time, data, last, fend);
                errors++;
                return;
            end
            e = pending.pop_front();
            if ({e.blue, e.green, e.red} !== data || e.run_end !== last
                || e.frame_end !== fend)
            begin
                $display("%0t: expected rgb %h last %b frame_end %b, got %h %b %b", $time,
                         {e.blue, e.green, e.red}, e.run_end, e.frame_end, data, last, fend);
                errors++;
            end
            else
                matched++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rgb_scoreboard pix_sb;
    bit            tx_idle_on;
    bit            rx_idle_on;
    int            hold_cycles;
    int            items_sent;
    int            frames_done;

    bayer_demosaic_mhc_5x5 u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // Downstream side: random stalls plus an optional long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready = 1'b0;
                hold_cycles--;
            end
            else
                m_tready = !rx_idle_on || ($urandom_range(99) >= 29);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            pix_sb.check_result(m_tdata, m_tlast, m_tuser[0]);
    end

    task automatic send_item(bit flush, byte unsigned pixel);
        while (tx_idle_on && $urandom_range(99) < 29)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = pixel;
        s_tuser  = flush;
        do
            @(posedge clk);
        while (!s_tready);
        pix_sb.note_input(flush, pixel);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_and_write(reg_idx_t idx, int value);
        s_tvalid = 1'b0;
        while (pix_sb.pending.size() != 0)
            @(negedge clk);
        // flushes into the first rows leave no result, so let the pipe settle
        repeat (12) @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pix_sb.write_reg(idx, value);
    endtask

    function automatic byte unsigned rand_pixel();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One frame in raster order with stray flushes, then a tail of flushes and pixels
    task automatic run_frame(int w, int h);
        for (int i = 0; i < w * h; i++)
        begin
            if ($urandom_range(99) < 5)
                send_item(1'b1, 8'($urandom_range(255)));
            send_item(1'b0, rand_pixel());
        end
        for (int i = 0; i < 2 * w; i++)
            send_item($urandom_range(99) < 70, 8'($urandom_range(255)));
        frames_done++;
    endtask

    task automatic set_size(int w, int h);
        drain_and_write(REG_FRAME_WIDTH, w);
        drain_and_write(REG_FRAME_HEIGHT, h);
    endtask

    initial
    begin
        int w;
        int h;
        pix_sb      = new();
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        hold_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Smallest frame, vertical stripes of extremes to hit both saturation limits
        set_size(5, 5);
        send_item(1'b1, 8'hff);
        for (int i = 0; i < 25; i++)
            send_item(1'b0, ((i / 5 + i) % 2) ? 8'hff : 8'h00);
        for (int i = 0; i < 10; i++)
            send_item(i % 2, 8'h5a);

        // Long downstream hold-off while the sender keeps pushing
        set_size(9, 6);
        hold_cycles = 400;
        run_frame(9, 6);

        // One full frame with no idling on either side
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_size(11, 8);
        run_frame(11, 8);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        while (items_sent < 340)
        begin
            w = $urandom_range(5, 11);
            h = $urandom_range(5, 8);
            set_size(w, h);
            run_frame(w, h);
            if ($urandom_range(1) && items_sent < 300)
                run_frame(w, h);
        end

        // Upper register bits drop and a zero height clamps up to the minimum
        drain_and_write(REG_FRAME_WIDTH, 'h1805);
        drain_and_write(REG_FRAME_HEIGHT, 0);
        run_frame(5, 5);

        s_tvalid = 1'b0;
        while (pix_sb.pending.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        $display("Covered %0d input transfers over %0d frames, %0d pixels matched.",
                 items_sent, frames_done, pix_sb.matched);
        $display("Sizes ran from 5x5 to 11x8, with masked and clamped sizes, stalls and flushes.");
        if (pix_sb.errors == 0 && pix_sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
